// ===== design/apr_pkg.sv =====
// Shared types and constants for the aging page replacement unit.
// No dependencies; imported by the cell, the chain and the top level.
`default_nettype none

package apr_pkg;

	localparam int AGE_W = 32;

	// func codes of an input transfer
	localparam logic [1:0] FUNC_REF    = 2'd0;
	localparam logic [1:0] FUNC_LOAD   = 2'd1;
	localparam logic [1:0] FUNC_SELECT = 2'd2;

	localparam logic [7:0] FRAMES_USED_RESET = 8'd128;

	// Commands from the control block to the row of frame cells
	typedef struct packed {
		logic ref_en;
		logic load_en;
		logic start_en;
		logic kill;
	} chain_cmd_t;

	// Per-cell commands after frame decode
	typedef struct packed {
		logic ref_set;
		logic load_clr;
		logic start;
		logic last;
		logic kill;
	} cell_ctl_t;

	// Per-cell status
	typedef struct packed {
		logic tok_fwd;
		logic tok_wrap;
		logic hit;
	} cell_stat_t;

endpackage

`default_nettype wire

// ===== design/aging_page_replacement_unit.sv =====
// Aging page replacement unit: input stream of reference, load and select
// commands, output stream of victims. Depends on apr_pkg and apr_chain.
//
// Usage:
//   s_tdata carries func and frame_number. A reference sets the frame's
//   referenced bit, a load clears its age; neither gives an output
//   transfer. A select walks a token through the row of frame cells,
//   one frame per cycle, starting at the hand and wrapping at the last frame
//   in use. Each visited cell ages itself; the control block updates the
//   running minimum in the cycle after each visit. The walk ends at the first
//   frame whose age becomes zero or after all frames in use.
//   A select of k visited frames (k <= frames in use) shows its victim on
//   m_tdata once the token walk and the finish and hold states are through.
//   s_tready is high only while no select is in progress, so the next
//   transfer is taken in the cycle the victim first shows; a new select is
//   not taken before the last one has placed its victim.
//   The result sits in an output register: while the receiver stalls,
//   references and loads are still taken and a further select runs its walk,
//   then waits for the register to drain.
//   Reset clears all ages, referenced bits and the hand, and sets
//   frames_used to 128. cfg_wdata is written whenever cfg_we is high.
`default_nettype none

module aging_page_replacement_unit
	import apr_pkg::*;
#(
	parameter int FRAMES = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,    // frames_used
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,      // [1:0] func, [8:2] frame_number
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata       // [6:0] victim_frame, [38:7] victim_age
);

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int NW = $clog2(FRAMES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	logic [1:0]       state_q;
	logic [7:0]       frames_used_q;
	logic [IW-1:0]    hand_q;
	logic [IW-1:0]    pos_q;
	logic [IW-1:0]    cnt_q;
	logic             v_s1;
	logic             first_s1;
	logic [IW-1:0]    pos_s1;
	logic [AGE_W-1:0] best_q;
	logic [IW-1:0]    bidx_q;
	logic             out_valid_q;
	logic [6:0]       out_frame_q;
	logic [AGE_W-1:0] out_age_q;

	logic [NW-1:0]    n_act;
	logic [IW-1:0]    last_idx;
	logic [IW-1:0]    start_idx;
	logic [IW-1:0]    frame_idx;
	logic [1:0]       func;
	logic [6:0]       frame;
	logic             in_table;
	logic             acc;
	logic             scan_end;
	logic             take;
	logic             out_free;
	chain_cmd_t       cmd;
	logic             hit;
	logic [AGE_W-1:0] age_out;

	assign func  = s_tdata[1:0];
	assign frame = s_tdata[8:2];

	always_comb begin
		if (frames_used_q == 8'd0) begin
			n_act = NW'(1);
		end else if (int'(frames_used_q) > FRAMES) begin
			n_act = NW'(FRAMES);
		end else begin
			n_act = NW'(frames_used_q);
		end
	end

	assign last_idx  = IW'(n_act - NW'(1));
	assign start_idx = (int'(hand_q) >= int'(n_act)) ? '0 : hand_q;
	assign in_table  = int'(frame) < FRAMES;
	assign frame_idx = IW'(frame);

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid & s_tready;
	assign scan_end = (state_q == ST_SCAN) & (hit | (cnt_q == last_idx));

	assign cmd.ref_en   = acc & (func == FUNC_REF) & in_table;
	assign cmd.load_en  = acc & (func == FUNC_LOAD) & in_table;
	assign cmd.start_en = acc & (func == FUNC_SELECT);
	assign cmd.kill     = (state_q == ST_SCAN) & (cnt_q == last_idx);

	apr_chain #(
		.FRAMES (FRAMES)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.frame_idx (frame_idx),
		.start_idx (start_idx),
		.last_idx  (last_idx),
		.hit       (hit),
		.age_out   (age_out)
	);

	// strict less keeps the first minimum in scan order
	assign take     = first_s1 | (age_out < best_q);
	assign out_free = ~out_valid_q | m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_age_q, out_frame_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_used_q <= FRAMES_USED_RESET;
		end else if (cfg_we) begin
			frames_used_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hand_q      <= '0;
			pos_q       <= '0;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			first_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1     <= (state_q == ST_SCAN);
			first_s1 <= (state_q == ST_SCAN) & (cnt_q == '0);
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.start_en) begin
						pos_q   <= start_idx;
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					pos_q <= (pos_q == last_idx) ? '0 : pos_q + IW'(1);
					cnt_q <= cnt_q + IW'(1);
					if (scan_end) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						hand_q      <= (bidx_q == last_idx) ? '0 : bidx_q + IW'(1);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// running minimum, registered in the cycle after the token visits a cell
	always_ff @(posedge clk) begin
		pos_s1 <= pos_q;
		if (v_s1 && take) begin
			best_q <= age_out;
			bidx_q <= pos_s1;
		end
		if (state_q == ST_HOLD && out_free) begin
			out_frame_q <= 7'(bidx_q);
			out_age_q   <= best_q;
		end
	end

	a_hit_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && hit) |=> (state_q == ST_FIN))
		else $error("zero age did not end the scan");

	a_out_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_HOLD))
		else $error("result shown without a finished select");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q <= last_idx))
		else $error("scan ran past the frames in use");

endmodule

`default_nettype wire

// ===== design/apr_cell.sv =====
// One frame cell: age counter, referenced bit and the scan token.
// Depends on apr_pkg.
`default_nettype none

module apr_cell
	import apr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_ctl_t        ctl,
	input  wire logic             tok_in,
	output cell_stat_t            stat,
	output logic [AGE_W-1:0]      age_sel
);

	logic             tok_q;
	logic             was_q;
	logic             ref_q;
	logic [AGE_W-1:0] age_q;
	logic [AGE_W-1:0] aged;
	logic             zero;
	logic             pass;

	assign aged = {ref_q, age_q[AGE_W-1:1]};
	assign zero = (aged == '0);
	// a zero age ends the scan here: the token is not passed on
	assign pass = tok_q & ~zero & ~ctl.kill;

	assign stat.tok_fwd  = pass & ~ctl.last;
	assign stat.tok_wrap = pass & ctl.last;
	assign stat.hit      = tok_q & zero;

	// show the freshly aged value for one cycle after the visit
	assign age_sel = was_q ? age_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
			was_q <= 1'b0;
			ref_q <= 1'b0;
			age_q <= '0;
		end else begin
			tok_q <= ctl.start | tok_in;
			was_q <= tok_q;
			if (tok_q) begin
				age_q <= aged;
				ref_q <= 1'b0;
			end else begin
				if (ctl.load_clr) begin
					age_q <= '0;
				end
				if (ctl.ref_set) begin
					ref_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/apr_chain.sv =====
// Row of frame cells with the scan token passed cell to cell and wrapped
// at the last frame in use. Depends on apr_pkg and apr_cell.
`default_nettype none

module apr_chain
	import apr_pkg::*;
#(
	parameter int FRAMES = 128,
	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire chain_cmd_t       cmd,
	input  wire logic [IW-1:0]    frame_idx,
	input  wire logic [IW-1:0]    start_idx,
	input  wire logic [IW-1:0]    last_idx,
	output logic                  hit,
	output logic [AGE_W-1:0]      age_out
);

	cell_ctl_t        ctl   [FRAMES];
	cell_stat_t       stat  [FRAMES];
	logic [AGE_W-1:0] ages  [FRAMES];
	logic             tok_in [FRAMES];
	logic             wrap;

	always_comb begin
		wrap    = 1'b0;
		hit     = 1'b0;
		age_out = '0;
		for (int i = 0; i < FRAMES; i++) begin
			wrap    = wrap | stat[i].tok_wrap;
			hit     = hit | stat[i].hit;
			age_out = age_out | ages[i];
		end
	end

	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		assign ctl[g].ref_set  = cmd.ref_en & (frame_idx == IW'(g));
		assign ctl[g].load_clr = cmd.load_en & (frame_idx == IW'(g));
		assign ctl[g].start    = cmd.start_en & (start_idx == IW'(g));
		assign ctl[g].last     = (last_idx == IW'(g));
		assign ctl[g].kill     = cmd.kill;

		if (g == 0) begin : g_head
			assign tok_in[g] = wrap;
		end else begin : g_body
			assign tok_in[g] = stat[g-1].tok_fwd;
		end

		apr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl[g]),
			.tok_in  (tok_in[g]),
			.stat    (stat[g]),
			.age_sel (ages[g])
		);
	end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for aging_page_replacement_unit: stream commands in,
// predict each victim with a local aging model, compare victim transfers.
// Depends on apr_pkg and the unit's RTL only.

module testbench;
	import apr_pkg::*;

	localparam int FRAMES = 128;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int LONG_HOLD = 800;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct {
		logic [1:0] func;
		logic [6:0] frame;
	} command_t;

	typedef struct {
		logic [6:0]  frame;
		logic [31:0] age;
	} victim_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	aging_page_replacement_unit #(.FRAMES(FRAMES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Local copy of the replacement state
	logic [31:0] ages [FRAMES];
	logic        refd [FRAMES];
	int unsigned hand;
	logic [7:0]  frames_used_reg;

	command_t pending_cmds[$];
	victim_t  expected_victims[$];

	int errors = 0;
	int cycles = 0;
	int cmds_taken = 0;
	int selects_taken = 0;
	int victims_checked = 0;
	int settings_used = 1;
	int idle_pct = 0;
	logic long_hold_go = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;

	task automatic report(input string msg);
		errors++;
		if (errors <= 30)
			$display("MISMATCH at cycle %0d: %s", cycles, msg);
	endtask

	function automatic int unsigned active_frames();
		if (frames_used_reg == 8'd0)
			return 1;
		if (frames_used_reg > FRAMES)
			return FRAMES;
		return 32'(frames_used_reg);
	endfunction

	// Age the frames in scan order from the hand; stop early at a zero age
	function automatic victim_t age_and_choose();
		int unsigned n, pos, best;
		logic [31:0] a;
		victim_t v;
		n = active_frames();
		pos = (hand >= n) ? 0 : hand;
		best = pos;
		for (int i = 0; i < n; i++) begin
			a = ages[pos] >> 1;
			if (refd[pos]) begin
				a[31] = 1'b1;
				refd[pos] = 1'b0;
			end
			ages[pos] = a;
			if (a == 32'd0) begin
				best = pos;
				break;
			end
			if (i == 0 || a < ages[best])
				best = pos;
			pos = (pos + 1) % n;
		end
		hand = (best + 1) % n;
		v.frame = best[6:0];
		v.age = ages[best];
		return v;
	endfunction

	function automatic void predict_command(input logic [1:0] func, input logic [6:0] frame);
		case (func)
			FUNC_REF: refd[frame] = 1'b1;
			FUNC_LOAD: ages[frame] = 32'd0;
			FUNC_SELECT: begin
				expected_victims.push_back(age_and_choose());
				selects_taken++;
			end
			default: ;
		endcase
	endfunction

	function automatic void add_cmd(input logic [1:0] func, input logic [6:0] frame);
		command_t c;
		c.func = func;
		c.frame = frame;
		pending_cmds.push_back(c);
	endfunction

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout with %0d victims outstanding", expected_victims.size());
			$display("testbench failed");
			$finish;
		end
	end

	// Command driver: hold while stalled, otherwise idle in bursts or send the next one
	always @(posedge clk) begin : drive_commands
		command_t c;
		if (!(s_tvalid && !s_tready)) begin
			if (gap_left != 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				s_tvalid <= 1'b0;
				gap_left <= $urandom_range(0, 15);
			end else if (pending_cmds.size() != 0) begin
				c = pending_cmds.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {7'd0, c.frame, c.func};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			cmds_taken++;
			predict_command(s_tdata[1:0], s_tdata[8:2]);
		end
	end

	// Victim receiver: one long hold on request, else random stall bursts
	always @(posedge clk) begin
		if (long_hold_go) begin
			hold_left <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_left <= $urandom_range(0, 15);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_victims
		victim_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_victims.size() == 0) begin
				report($sformatf("victim transfer frame %0d with none pending", m_tdata[6:0]));
			end else begin
				want = expected_victims.pop_front();
				victims_checked++;
				if (m_tdata[6:0] !== want.frame)
					report($sformatf("victim_frame %0d, want %0d", m_tdata[6:0], want.frame));
				if (m_tdata[38:7] !== want.age)
					report($sformatf("victim_age %h, want %h (frame %0d)",
						m_tdata[38:7], want.age, want.frame));
			end
		end
	end

	task automatic wait_idle();
		while (pending_cmds.size() != 0 || s_tvalid || expected_victims.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_frames_used(input logic [7:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		frames_used_reg = value;
		settings_used++;
	endtask

	function automatic logic [6:0] pick_frame(input int unsigned span);
		if ($urandom_range(0, 99) < 85)
			return 7'($urandom_range(0, span - 1));
		return 7'($urandom_range(0, FRAMES - 1));
	endfunction

	// Random traffic: mostly references and selects, with sweeps that
	// reference a run of frames so full-length scans happen too
	task automatic queue_mix(input int count);
		int made, kind, len, start;
		int unsigned span;
		span = active_frames();
		made = 0;
		while (made < count) begin
			kind = $urandom_range(0, 99);
			if (kind < ((span > 32) ? 3 : 8)) begin
				len = ($urandom_range(0, 2) == 0) ? span : $urandom_range(1, span);
				start = $urandom_range(0, span - 1);
				for (int k = 0; k < len; k++)
					add_cmd(FUNC_REF, 7'((start + k) % span));
				made += len;
			end else if (kind < 50) begin
				add_cmd(FUNC_REF, pick_frame(span));
				made++;
			end else if (kind < 60) begin
				add_cmd(FUNC_LOAD, pick_frame(span));
				made++;
			end else if (kind < 96) begin
				add_cmd(FUNC_SELECT, 7'($urandom_range(0, FRAMES - 1)));
				made++;
			end else begin
				add_cmd(FUNC_UNUSED, 7'($urandom_range(0, FRAMES - 1)));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < FRAMES; i++) begin
			ages[i] = 32'd0;
			refd[i] = 1'b0;
		end
		hand = 0;
		frames_used_reg = FRAMES_USED_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset state, both frame extremes, every func code
		idle_pct = 20;
		add_cmd(FUNC_SELECT, 7'd0);
		add_cmd(FUNC_REF, 7'd0);
		add_cmd(FUNC_REF, 7'd127);
		add_cmd(FUNC_LOAD, 7'd127);
		add_cmd(FUNC_UNUSED, 7'd127);
		add_cmd(FUNC_REF, 7'd1);
		add_cmd(FUNC_SELECT, 7'd127);
		add_cmd(FUNC_LOAD, 7'd0);
		add_cmd(FUNC_SELECT, 7'd0);
		add_cmd(FUNC_REF, 7'd2);
		add_cmd(FUNC_REF, 7'd3);
		add_cmd(FUNC_REF, 7'd4);
		add_cmd(FUNC_SELECT, 7'd0);
		add_cmd(FUNC_UNUSED, 7'd0);
		add_cmd(FUNC_LOAD, 7'd127);
		add_cmd(FUNC_REF, 7'd127);
		add_cmd(FUNC_SELECT, 7'd64);
		add_cmd(FUNC_SELECT, 7'd0);
		wait_idle();

		// One frame in use; the hand is left outside the range
		write_frames_used(8'd1);
		add_cmd(FUNC_SELECT, 7'd0);
		add_cmd(FUNC_REF, 7'd100);
		add_cmd(FUNC_SELECT, 7'd0);
		queue_mix(120);
		wait_idle();

		// Zero is taken as one frame
		write_frames_used(8'd0);
		idle_pct = 10;
		queue_mix(100);
		wait_idle();

		// Above the table size; hold the receiver off so the unit stalls its input
		write_frames_used(8'd255);
		idle_pct = 0;
		@(posedge clk);
		long_hold_go <= 1'b1;
		@(posedge clk);
		long_hold_go <= 1'b0;
		for (int i = 0; i < 6; i++)
			add_cmd(FUNC_SELECT, 7'($urandom_range(0, FRAMES - 1)));
		queue_mix(200);
		wait_idle();

		write_frames_used(8'd5);
		idle_pct = 15;
		queue_mix(300);
		wait_idle();

		write_frames_used(8'd16);
		idle_pct = 35;
		queue_mix(300);
		wait_idle();

		write_frames_used(8'($urandom_range(2, 127)));
		idle_pct = 5;
		queue_mix(250);
		wait_idle();

		// Closing stretch with no idling on either side
		write_frames_used(8'd128);
		idle_pct = 0;
		queue_mix(350);
		wait_idle();
		repeat (20) @(posedge clk);

		if (expected_victims.size() != 0)
			report($sformatf("%0d victims never arrived", expected_victims.size()));
		$display("covered %0d commands, %0d selects, %0d frames_used settings",
			cmds_taken, selects_taken, settings_used);
		$display("checked %0d victim transfers, %0d mismatches", victims_checked, errors);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
